### rtl/divide_128_quotient_remainder_unit_defines.svh
// Assertion macros used by the controller of the 128-bit divider RTL
`ifndef DIVIDE_128_QUOTIENT_REMAINDER_UNIT_DEFINES_SVH
`define DIVIDE_128_QUOTIENT_REMAINDER_UNIT_DEFINES_SVH

// Property checked at every rising clock edge outside reset
`define DIV128QR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication outside reset
`define DIV128QR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication outside reset
`define DIV128QR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/div128qr_pkg.sv
// Types and constants of the 128-bit divider
`default_nettype none

package div128qr_pkg;

  localparam int unsigned HALF_W = 64;
  localparam int unsigned FULL_W = 2 * HALF_W;
  localparam int unsigned STEPS  = FULL_W;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  typedef struct packed {
    logic [HALF_W-1:0] dividend_hi;
    logic [HALF_W-1:0] dividend_lo;
    logic [HALF_W-1:0] divisor_hi;
    logic [HALF_W-1:0] divisor_lo;
  } div128qr_in_t;

  typedef struct packed {
    logic [HALF_W-1:0] quotient_hi;
    logic [HALF_W-1:0] quotient_lo;
    logic [HALF_W-1:0] remainder_hi;
    logic [HALF_W-1:0] remainder_lo;
    logic              zero_divisor;
  } div128qr_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } div128qr_cmd_t;

  typedef struct packed {
    logic div_zero;
  } div128qr_stat_t;

endpackage

`default_nettype wire

### rtl/div128qr_dp.sv
// Datapath of the 128-bit divider: remainder, quotient and divisor registers
`default_nettype none

module div128qr_dp (
  input  wire                         clk,
  input  wire div128qr_pkg::div128qr_cmd_t  cmd,
  input  wire div128qr_pkg::div128qr_in_t   req,
  output div128qr_pkg::div128qr_stat_t      status,
  output div128qr_pkg::div128qr_out_t       rsp
);
  import div128qr_pkg::*;

  logic [FULL_W-1:0] rem;
  logic [FULL_W-1:0] quo;
  logic [FULL_W-1:0] den;
  logic              div_zero;

  logic [FULL_W:0]   trial;
  logic [FULL_W+1:0] diff;
  logic              borrow;

  // shift one dividend bit into the partial remainder and try the subtract
  assign trial  = {rem, quo[FULL_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, den};
  assign borrow = diff[FULL_W+1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem      <= '0;
      quo      <= {req.dividend_hi, req.dividend_lo};
      den      <= {req.divisor_hi, req.divisor_lo};
      div_zero <= ({req.divisor_hi, req.divisor_lo} == '0);
    end else if (cmd.step) begin
      rem <= borrow ? trial[FULL_W-1:0] : diff[FULL_W-1:0];
      quo <= {quo[FULL_W-2:0], ~borrow};
    end
  end

  assign status.div_zero = div_zero;

  always_comb begin
    rsp              = '0;
    rsp.zero_divisor = div_zero;
    if (!div_zero) begin
      rsp.quotient_hi  = quo[FULL_W-1:HALF_W];
      rsp.quotient_lo  = quo[HALF_W-1:0];
      rsp.remainder_hi = rem[FULL_W-1:HALF_W];
      rsp.remainder_lo = rem[HALF_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/div128qr_ctrl.sv
// Controller of the 128-bit divider: sequences the shift-subtract steps
`default_nettype none

`include "divide_128_quotient_remainder_unit_defines.svh"

module div128qr_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire div128qr_pkg::div128qr_stat_t  status,
  output logic                         busy,
  output logic                         done,
  output div128qr_pkg::div128qr_cmd_t        cmd
);
  import div128qr_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             last;

  assign last     = (cnt == CNT_W'(STEPS - 1));
  assign cmd.load = (state == IDLE) && start;
  assign cmd.step = (state == RUN) && !status.div_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= RUN;
            busy  <= 1'b1;
            cnt   <= '0;
          end
        end
        RUN: begin
          if (status.div_zero || last) begin
            state <= IDLE;
            busy  <= 1'b0;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

  `DIV128QR_ASSERT(a_done_not_busy, !(done && busy), "result strobe while busy")
  `DIV128QR_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `DIV128QR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  `DIV128QR_ASSERT_IMPL(a_busy_state, busy, state == RUN, "busy outside the run state")

endmodule

`default_nettype wire

### rtl/divide_128_quotient_remainder_unit.sv
// Top level of the unsigned 128-bit quotient and remainder divider
// Operation: one restoring shift-subtract step per quotient bit, 128 steps,
//   from the accepting edge to the done strobe; a zero divisor skips the
//   steps. The single 129-bit subtractor serves all steps, so no new item
//   is taken while busy. A new item may be started in the done cycle.
// Reset: synchronous, active high; clears the controller, the datapath
//   holds no control state. The receiver cannot stall the result.
`default_nettype none

module divide_128_quotient_remainder_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire div128qr_pkg::div128qr_in_t  req,
  output logic                             busy,
  output logic                             done,
  output div128qr_pkg::div128qr_out_t      rsp
);
  import div128qr_pkg::*;

  div128qr_cmd_t  cmd;
  div128qr_stat_t status;

  div128qr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  div128qr_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire
